@@ src/dmacfm_pkg.sv @@
// ----------------------------------------------------------------------------
// DMA command FIFO block mover - shared package
// Queue sizing, bus operation codes and the structs passed between the
// queue, the controller and the top level.
// ----------------------------------------------------------------------------
package dmacfm_pkg;

	// command queue sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int WORD_W      = 32;

	// stream widths
	localparam int IN_DATA_W  = 32;
	localparam int IN_USER_W  = 8;
	localparam int OUT_DATA_W = 72;

	// bus operation codes
	typedef logic [1:0] bus_op_t;
	localparam bus_op_t OP_PUSH   = 2'd0;
	localparam bus_op_t OP_STATUS = 2'd1;
	localparam bus_op_t OP_TICK   = 2'd2;

	// queue requests from the controller
	typedef struct packed {
		logic push;
		logic pop;
	} fifo_req_t;

	// queue status back to the controller
	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	// one result item
	typedef struct packed {
		logic              block_last;
		logic              block_masked;
		logic [WORD_W-1:0] block_target;
		logic [WORD_W-1:0] block_source;
		logic              block_valid;
		logic              fifo_overflow;
		logic              status_word;
	} result_t;

endpackage

@@ src/dma_command_fifo_block_mover.sv @@
// ----------------------------------------------------------------------------
// DMA command FIFO block mover - top level
// Input register, command queue, sequencer and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_*: one bus item per transfer. tuser carries the bus
//   operation (push word, read status, clock tick), tdata the word to push.
//   Master stream m_axis_*: exactly one result per bus item, in order. tdata
//   carries the status bit, the overflow flag and the block command; tlast
//   marks the final block of a copy.
//   Path: an accepted item is held in the input register, and its result
//   is loaded into the output register once that register is free or
//   draining, and is then offered on m_axis.
//   Throughput: one item per cycle while m_axis_tready stays high; the
//   queue and sequencer registers update in the same cycle that produces
//   the result, so the next item sees them.
//   Reset (arst_n low): queue empty, sequencer idle, burst count one,
//   addresses zero, m_axis_tvalid low and s_axis_tready high.
//   Receiver stall: the result waits in the output register; one more item
//   is held in the input register, then s_axis_tready drops until the
//   receiver takes the waiting result.
// ----------------------------------------------------------------------------
module dma_command_fifo_block_mover (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [31:0] word
	input  logic [dmacfm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] op, [7:2] zero
	input  logic [dmacfm_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] status_word, [1] fifo_overflow, [2] block_valid, [34:3] block_source,
	// [66:35] block_target, [67] block_masked, [71:68] zero
	output logic [dmacfm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                              m_axis_tlast
);
	import dmacfm_pkg::*;

	logic              valid_s1;
	bus_op_t           op_s1;
	logic [WORD_W-1:0] word_s1;

	logic              out_valid_q;
	result_t           out_q;

	logic              fire;
	fifo_req_t         freq;
	fifo_stat_t        fstat;
	logic [WORD_W-1:0] head_word;
	result_t           result;

	// the held item moves on when the output register is free or draining
	assign fire          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser[1:0];
			word_s1 <= s_axis_tdata[WORD_W-1:0];
		end
	end

	dmacfm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (freq),
		.wdata     (word_s1),
		.stat      (fstat),
		.head_word (head_word)
	);

	dmacfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.op        (op_s1),
		.fstat     (fstat),
		.head_word (head_word),
		.freq      (freq),
		.result    (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_q.block_last;
	assign m_axis_tdata  = {4'b0000, out_q.block_masked, out_q.block_target,
		out_q.block_source, out_q.block_valid, out_q.fifo_overflow,
		out_q.status_word};

	// checks
	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result not registered");
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled while input register empty");
	a_no_fire_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !fire)
		else $error("result overwritten while stalled");

endmodule

@@ src/dmacfm_fifo.sv @@
// ----------------------------------------------------------------------------
// DMA command FIFO block mover - command queue
// Circular buffer of command words with head/tail pointers and a fill count.
// The head word is kept in a register so a pop can consume it in the same cycle.
// ----------------------------------------------------------------------------
module dmacfm_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dmacfm_pkg::fifo_req_t         req,
	input  logic [dmacfm_pkg::WORD_W-1:0] wdata,
	output dmacfm_pkg::fifo_stat_t        stat,
	output logic [dmacfm_pkg::WORD_W-1:0] head_word
);
	import dmacfm_pkg::*;

	logic [WORD_W-1:0] entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QCNT_W-1:0] count_q;
	logic [WORD_W-1:0] head_word_q;
	logic [QPTR_W-1:0] head_next;

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
	localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);
	localparam logic [QCNT_W-1:0] CNT_ONE  = QCNT_W'(1);

	// status and head word
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_FULL);
	assign head_word  = head_word_q;
	assign head_next  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;

	// storage and head word, no reset needed
	always_ff @(posedge clk) begin
		if (req.push) begin
			entry_q[tail_q] <= wdata;
		end
		if (req.pop) begin
			head_word_q <= (req.push && count_q == CNT_ONE) ? wdata : entry_q[head_next];
		end else if (req.push && stat.empty) begin
			head_word_q <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (req.push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
			end
			if (req.pop) begin
				head_q <= head_next;
			end
			if (req.push && !req.pop) begin
				count_q <= count_q + 1'b1;
			end else if (req.pop && !req.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// checks
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		req.push |-> !stat.full)
		else $error("push into full command queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		req.pop |-> !stat.empty)
		else $error("pop from empty command queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("command queue count out of range");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.push && !req.pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push did not grow the queue");

endmodule

@@ src/dmacfm_ctrl.sv @@
// ----------------------------------------------------------------------------
// DMA command FIFO block mover - controller
// Decodes one registered bus item per fired cycle: pushes, status reads and ticks
// of the command sequencer, which emits at most one block command per tick.
// ----------------------------------------------------------------------------
module dmacfm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  dmacfm_pkg::bus_op_t           op,
	input  dmacfm_pkg::fifo_stat_t        fstat,
	input  logic [dmacfm_pkg::WORD_W-1:0] head_word,
	output dmacfm_pkg::fifo_req_t         freq,
	output dmacfm_pkg::result_t           result
);
	import dmacfm_pkg::*;

	// sequencer phases
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_DISPATCH = 3'd1;
	localparam logic [2:0] PH_PLAIN    = 3'd2;
	localparam logic [2:0] PH_MASKED   = 3'd3;
	localparam logic [2:0] PH_FINAL    = 3'd4;

	// command opcodes
	localparam logic [7:0] CMD_SET_SRC   = 8'h00;
	localparam logic [7:0] CMD_SET_DST   = 8'h01;
	localparam logic [7:0] CMD_SET_BURST = 8'h02;
	localparam logic [7:0] CMD_COPY      = 8'h03;
	localparam logic [7:0] CMD_TAG       = 8'h04;

	localparam logic [WORD_W-1:0] BLOCK_BYTES = WORD_W'(16);
	localparam logic [WORD_W-1:0] ALIGN_MASK  = ~WORD_W'(32'hF);

	logic [2:0]        phase_q, phase_d;
	logic [WORD_W-1:0] cmd_q, cmd_d;
	logic [WORD_W-1:0] src_q, src_d;
	logic [WORD_W-1:0] tgt_q, tgt_d;
	logic [8:0]        burst_q, burst_d;
	logic [8:0]        done_q, done_d;

	logic [7:0]        opc;
	logic [8:0]        done_inc;
	logic [8:0]        burst_m1;
	logic [WORD_W-1:0] offset;
	logic              tick;

	assign opc      = cmd_q[7:0];
	assign done_inc = done_q + 9'd1;
	assign burst_m1 = burst_q - 9'd1;
	assign offset   = {{(WORD_W-13){1'b0}}, done_q, 4'b0000};
	assign tick     = fire && (op == OP_TICK);

	// next state and result for the item in hand
	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		src_d   = src_q;
		tgt_d   = tgt_q;
		burst_d = burst_q;
		done_d  = done_q;
		freq    = '0;
		result  = '0;

		priority if (op == OP_PUSH) begin
			result.fifo_overflow = fstat.full;
			freq.push            = fire && !fstat.full;
		end else if (op == OP_STATUS) begin
			result.status_word = !fstat.empty;
		end else if (op == OP_TICK) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (!fstat.empty) begin
						freq.pop = fire;
						cmd_d    = head_word;
						phase_d  = PH_DISPATCH;
					end
				end
				PH_DISPATCH: begin
					if (opc == CMD_COPY) begin
						done_d  = '0;
						phase_d = cmd_q[8] ? PH_MASKED : PH_PLAIN;
					end else if (opc <= CMD_TAG) begin
						if (!fstat.empty) begin
							freq.pop = fire;
							phase_d  = PH_IDLE;
							if (opc == CMD_SET_SRC) begin
								src_d = head_word;
							end else if (opc == CMD_SET_DST) begin
								tgt_d = head_word;
							end else if (opc == CMD_SET_BURST) begin
								burst_d = {1'b0, head_word[7:0]} + 9'd1;
							end
						end
					end else begin
						phase_d = PH_FINAL;
					end
				end
				PH_PLAIN: begin
					result.block_valid  = 1'b1;
					result.block_source = src_q & ALIGN_MASK;
					result.block_target = tgt_q;
					result.block_last   = (done_inc >= burst_q);
					src_d = src_q + BLOCK_BYTES;
					tgt_d = tgt_q + BLOCK_BYTES;
					if (done_inc >= burst_q) begin
						done_d  = '0;
						phase_d = PH_IDLE;
					end else begin
						done_d = done_inc;
					end
				end
				PH_MASKED: begin
					if (burst_q <= 9'd1 || done_q >= burst_m1) begin
						done_d  = '0;
						phase_d = PH_IDLE;
					end else begin
						result.block_valid  = 1'b1;
						result.block_source = src_q + offset;
						result.block_target = tgt_q + offset;
						result.block_masked = 1'b1;
						result.block_last   = (done_inc >= burst_m1);
						if (done_inc >= burst_m1) begin
							done_d  = '0;
							phase_d = PH_IDLE;
						end else begin
							done_d = done_inc;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end else begin
			// reserved op: no effect
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= '0;
			src_q   <= '0;
			tgt_q   <= '0;
			burst_q <= 9'd1;
			done_q  <= '0;
		end else if (tick) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			src_q   <= src_d;
			tgt_q   <= tgt_d;
			burst_q <= burst_d;
			done_q  <= done_d;
		end
	end

	// checks
	a_block_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result.block_valid |-> (op == OP_TICK))
		else $error("block command outside a tick");
	a_last_needs_block: assert property (@(posedge clk) disable iff (!arst_n)
		result.block_last |-> result.block_valid)
		else $error("last flag without a block");
	a_burst_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(burst_q != 9'd0) && (burst_q <= 9'd256))
		else $error("burst count out of range");
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && result.block_last) |=> (phase_q == PH_IDLE && done_q == 9'd0))
		else $error("last block did not end the transfer");

endmodule
